// ===== rtl/dns_question_name_encoder_defines.svh =====
// assertion macros shared by the encoder modules
`ifndef DNS_QUESTION_NAME_ENCODER_DEFINES_SVH
`define DNS_QUESTION_NAME_ENCODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DQNE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define DQNE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dqne_pkg.sv =====
// types and constants of the dns question name encoder
package dqne_pkg;

	localparam int DEF_MAX_NAME_BYTES  = 255;
	localparam int DEF_MAX_LABEL_BYTES = 63;

	localparam logic [7:0] DOT_CHAR = 8'h2E;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_TYPE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_CLASS = 2'd1;
	localparam logic [CFG_DATA_W-1:0]  QUERY_TYPE_RESET  = 16'd1;
	localparam logic [CFG_DATA_W-1:0]  QUERY_CLASS_RESET = 16'd1;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_LABEL_LONG = 2'd1;
	localparam logic [1:0] ST_NAME_LONG  = 2'd2;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_SINGLE    = 2'd0;
	localparam kind_t KIND_ERROR     = 2'd1;
	localparam kind_t KIND_END_EMPTY = 2'd2;
	localparam kind_t KIND_END_FULL  = 2'd3;

	typedef struct packed {
		kind_t      kind;
		logic [8:0] base;
		logic [7:0] slot;
		logic [7:0] value;
	} cmd_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== rtl/dqne_if.sv =====
// valid/ready channel interfaces for name bytes and wire writes
interface dqne_name_if;
	logic       valid;
	logic       ready;
	logic [7:0] name_byte;
	logic       end_of_name;

	modport source (output valid, output name_byte, output end_of_name, input ready);
	modport sink (input valid, input name_byte, input end_of_name, output ready);
endinterface

interface dqne_wire_if;
	logic       valid;
	logic       ready;
	logic [8:0] write_offset;
	logic [7:0] write_value;
	logic [1:0] status;
	logic       last;

	modport source (output valid, output write_offset, output write_value,
		output status, output last, input ready);
	modport sink (input valid, input write_offset, input write_value,
		input status, input last, output ready);
endinterface

// ===== rtl/dqne_front.sv =====
// front end: tracks label and name position, classifies each word into a command
module dqne_front #(
	parameter int MAX_NAME_BYTES  = dqne_pkg::DEF_MAX_NAME_BYTES,
	parameter int MAX_LABEL_BYTES = dqne_pkg::DEF_MAX_LABEL_BYTES
) (
	input  logic               clk,
	input  logic               arst_n,
	dqne_name_if.sink          name_in,
	input  logic               full,
	output logic               push,
	output dqne_pkg::cmd_t     push_cmd
);
	import dqne_pkg::*;

	logic [6:0] label_count_q;
	logic [7:0] length_slot_q;
	logic [8:0] write_position_q;
	logic       error_latched_q;

	logic fire;
	logic name_full;
	logic label_over;
	logic is_dot;

	assign name_in.ready = !full;
	assign fire       = name_in.valid && name_in.ready;
	assign name_full  = write_position_q >= 9'(MAX_NAME_BYTES);
	assign label_over = label_count_q > 7'(MAX_LABEL_BYTES);
	assign is_dot     = name_in.name_byte == DOT_CHAR;

	always_comb begin
		push           = 1'b0;
		push_cmd.kind  = KIND_SINGLE;
		push_cmd.base  = write_position_q;
		push_cmd.slot  = length_slot_q;
		push_cmd.value = name_in.name_byte;
		if (fire && !error_latched_q) begin
			push = 1'b1;
			if (name_in.end_of_name) begin
				if (label_count_q == 7'd0) begin
					push_cmd.kind = KIND_END_EMPTY;
					push_cmd.base = {1'b0, length_slot_q};
				end else if (name_full) begin
					push_cmd.kind  = KIND_ERROR;
					push_cmd.value = {6'd0, ST_NAME_LONG};
				end else if (label_over) begin
					push_cmd.kind  = KIND_ERROR;
					push_cmd.value = {6'd0, ST_LABEL_LONG};
				end else begin
					push_cmd.kind  = KIND_END_FULL;
					push_cmd.value = {1'b0, label_count_q};
				end
			end else if (is_dot) begin
				if (label_over) begin
					push_cmd.kind  = KIND_ERROR;
					push_cmd.value = {6'd0, ST_LABEL_LONG};
				end else if (name_full) begin
					push_cmd.kind  = KIND_ERROR;
					push_cmd.value = {6'd0, ST_NAME_LONG};
				end else begin
					push_cmd.base  = {1'b0, length_slot_q};
					push_cmd.value = {1'b0, label_count_q};
				end
			end else if (name_full) begin
				push_cmd.kind  = KIND_ERROR;
				push_cmd.value = {6'd0, ST_NAME_LONG};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_count_q    <= 7'd0;
			length_slot_q    <= 8'd0;
			write_position_q <= 9'd1;
			error_latched_q  <= 1'b0;
		end else if (fire) begin
			if (name_in.end_of_name) begin
				if (error_latched_q || label_count_q == 7'd0 || !(name_full || label_over)) begin
					label_count_q    <= 7'd0;
					length_slot_q    <= 8'd0;
					write_position_q <= 9'd1;
					error_latched_q  <= 1'b0;
				end else begin
					error_latched_q <= 1'b1;
				end
			end else if (!error_latched_q) begin
				if (is_dot) begin
					if (label_over || name_full) begin
						error_latched_q <= 1'b1;
					end else begin
						length_slot_q    <= write_position_q[7:0];
						write_position_q <= write_position_q + 9'd1;
						label_count_q    <= 7'd0;
					end
				end else if (name_full) begin
					error_latched_q <= 1'b1;
				end else begin
					write_position_q <= write_position_q + 9'd1;
					if (!label_over) begin
						label_count_q <= label_count_q + 7'd1;
					end
				end
			end
		end
	end

endmodule

// ===== rtl/dqne_fifo.sv =====
// short command queue between front and back end
`include "dns_question_name_encoder_defines.svh"

module dqne_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dqne_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output dqne_pkg::cmd_t head,
	output logic           empty
);
	import dqne_pkg::*;

	cmd_t                   entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign full  = count_q == QUEUE_CNT_W'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`DQNE_ASSERT_IMP(a_no_overflow, push, !full, "push into full queue")
	`DQNE_ASSERT_IMP(a_no_underflow, pop, !empty, "pop from empty queue")
	`DQNE_ASSERT_NEXT(a_push_lands, push && !pop, !empty, "pushed word missing from queue")

endmodule

// ===== rtl/dqne_back.sv =====
// back end: expands queued commands into wire writes, holds type and class
`include "dns_question_name_encoder_defines.svh"

module dqne_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dqne_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [dqne_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  dqne_pkg::cmd_t                     head,
	input  logic                               empty,
	output logic                               pop,
	dqne_wire_if.source                        wire_out
);
	import dqne_pkg::*;

	logic [CFG_DATA_W-1:0] query_type_q;
	logic [CFG_DATA_W-1:0] query_class_q;
	logic [2:0]            step_q;

	logic       valid_q;
	logic [8:0] offset_q;
	logic [7:0] value_q;
	logic [1:0] status_q;
	logic       last_q;

	logic       load;
	logic       final_step;
	logic [2:0] t_idx;
	logic [8:0] r_off;
	logic [7:0] r_val;
	logic [1:0] r_st;
	logic       r_last;
	logic [7:0] t_byte;

	always_comb begin
		case (t_idx)
			3'd1:    t_byte = query_type_q[15:8];
			3'd2:    t_byte = query_type_q[7:0];
			3'd3:    t_byte = query_class_q[15:8];
			3'd4:    t_byte = query_class_q[7:0];
			default: t_byte = 8'd0;
		endcase
	end

	always_comb begin
		r_off      = head.base;
		r_val      = 8'd0;
		r_st       = ST_OK;
		r_last     = 1'b0;
		final_step = 1'b0;
		t_idx      = 3'd0;
		case (head.kind)
			KIND_SINGLE: begin
				r_val      = head.value;
				final_step = 1'b1;
			end
			KIND_ERROR: begin
				r_off      = 9'd0;
				r_st       = head.value[1:0];
				r_last     = 1'b1;
				final_step = 1'b1;
			end
			KIND_END_EMPTY: begin
				if (step_q != 3'd0) begin
					t_idx = step_q;
					r_off = head.base + {6'd0, t_idx};
					r_val = t_byte;
					if (step_q == 3'd4) begin
						r_last     = 1'b1;
						final_step = 1'b1;
					end
				end
			end
			KIND_END_FULL: begin
				if (step_q == 3'd1) begin
					r_off = {1'b0, head.slot};
					r_val = head.value;
				end else if (step_q != 3'd0) begin
					t_idx = step_q - 3'd1;
					r_off = head.base + {6'd0, t_idx};
					r_val = t_byte;
					if (step_q == 3'd5) begin
						r_last     = 1'b1;
						final_step = 1'b1;
					end
				end
			end
			default: begin
				final_step = 1'b1;
			end
		endcase
	end

	assign load = !empty && (!valid_q || wire_out.ready);
	assign pop  = load && final_step;

	assign wire_out.valid        = valid_q;
	assign wire_out.write_offset = offset_q;
	assign wire_out.write_value  = value_q;
	assign wire_out.status       = status_q;
	assign wire_out.last         = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_type_q  <= QUERY_TYPE_RESET;
			query_class_q <= QUERY_CLASS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_QUERY_TYPE:  query_type_q  <= cfg_data;
				CFG_QUERY_CLASS: query_class_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q  <= 3'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				step_q  <= final_step ? 3'd0 : step_q + 3'd1;
			end else if (wire_out.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			offset_q <= r_off;
			value_q  <= r_val;
			status_q <= r_st;
			last_q   <= r_last;
		end
	end

	`DQNE_ASSERT_IMP(a_mid_entry_head, step_q != 3'd0, !empty, "command left mid expansion")
	`DQNE_ASSERT_IMP(a_last_ends_cmd, load && r_last, final_step, "last word before command end")
	`DQNE_ASSERT_NEXT(a_stall_holds, valid_q && !wire_out.ready, valid_q && $stable(offset_q) && $stable(value_q), "stalled word changed")

endmodule

// ===== rtl/dns_question_name_encoder.sv =====
// top level of the dns question name encoder
//
// name_in takes one word per cycle while its four-entry command queue has room:
// a name character, or end_of_name to close the name. wire_out gives
// (write_offset, write_value, status, last) words that build the wire question;
// last marks the final word of a name or an error. A character or dot gives one
// word, the terminator five or six words (zero, label length, type and class
// big-endian), an error one word with last set. Bytes after an error and the
// terminator that follows give no word. An accepted word passes the queue,
// then the output register. The back end issues one output word per cycle
// while wire_out is ready, so a terminator holds the output for its five or six
// words while the front keeps filling the queue. When wire_out stalls the
// output register holds and the queue absorbs up to four more commands before
// name_in.ready drops. cfg_we with cfg_index 0 or 1 sets query type or class;
// the user must do so only while idle, which the block does not enforce. Reset
// clears the name state and queue and sets type and class to 1.
module dns_question_name_encoder #(
	parameter int MAX_NAME_BYTES  = dqne_pkg::DEF_MAX_NAME_BYTES,
	parameter int MAX_LABEL_BYTES = dqne_pkg::DEF_MAX_LABEL_BYTES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	dqne_name_if.sink                        name_in,
	dqne_wire_if.source                      wire_out,
	input  logic                             cfg_we,
	input  logic [dqne_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [dqne_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import dqne_pkg::*;

	logic push;
	logic pop;
	logic full;
	logic empty;
	cmd_t push_cmd;
	cmd_t head;

	dqne_front #(
		.MAX_NAME_BYTES  (MAX_NAME_BYTES),
		.MAX_LABEL_BYTES (MAX_LABEL_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.name_in  (name_in),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	dqne_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	dqne_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.wire_out  (wire_out)
	);

endmodule
